FILE: src/srot_pkg.sv
package srot_pkg;

    // Default geometry: Q12.4 coordinates, Q16 slope fraction
    localparam int COORD_BITS_DEF      = 16;
    localparam int SLOPE_FRAC_BITS_DEF = 16;

    // Register port geometry
    localparam int CFG_DATA_BITS = 32;
    localparam int CFG_ADDR_BITS = 4;

    // Rectangle width and height after reset (1.0 in Q12.4)
    localparam int RECT_SIZE_RESET = 16;

    // Register map, indexed by paddr[3:2]
    typedef enum logic [1:0] {
        REG_RECT_LEFT   = 2'd0,
        REG_RECT_TOP    = 2'd1,
        REG_RECT_WIDTH  = 2'd2,
        REG_RECT_HEIGHT = 2'd3
    } srot_reg_t;

    // Per-transaction flags carried down the pipeline
    typedef struct packed {
        logic vert;   // dx is zero: use the endpoint y values
        logic miss;   // clamped x span is empty
    } srot_flags_t;

endpackage

FILE: src/srot_front.sv
module srot_front #(
    parameter int COORD_BITS      = srot_pkg::COORD_BITS_DEF,
    parameter int SLOPE_FRAC_BITS = srot_pkg::SLOPE_FRAC_BITS_DEF
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          in_valid,
    output logic                                          in_ready,
    input  logic signed [COORD_BITS-1:0]                  start_x,
    input  logic signed [COORD_BITS-1:0]                  start_y,
    input  logic signed [COORD_BITS-1:0]                  end_x,
    input  logic signed [COORD_BITS-1:0]                  end_y,
    input  logic signed [COORD_BITS-1:0]                  rect_left,
    input  logic signed [COORD_BITS:0]                    rect_right,
    output logic                                          out_valid,
    input  logic                                          out_ready,
    output logic [2*COORD_BITS+SLOPE_FRAC_BITS-1:0]       acc,
    output logic [COORD_BITS-1:0]                         denom,
    output logic signed [COORD_BITS:0]                    xlo_off,
    output logic signed [COORD_BITS:0]                    xhi_off,
    output logic signed [COORD_BITS-1:0]                  sy,
    output logic signed [COORD_BITS-1:0]                  ey,
    output srot_pkg::srot_flags_t                         flags
);
    import srot_pkg::*;

    localparam int C = COORD_BITS;
    localparam int F = SLOPE_FRAC_BITS;
    localparam int N = C + F;

    // Stage 0: sort x, take |dx| and |dy|, slope sign
    logic                s0_valid_reg, s0_valid_next, s0_ready, s0_load;
    logic signed [C-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic signed [C-1:0] s0_sx_reg, s0_sy_reg, s0_ey_reg;
    logic [C-1:0]        adx_reg, adx_next, ady_reg, ady_next;
    logic                neg_reg, neg_next, vert_reg, vert_next;
    logic signed [C:0]   dx, dy;

    // Stage 1: clamp x span, offsets from start_x with slope sign folded in
    logic                s1_valid_reg, s1_valid_next, s1_ready, s1_load;
    logic [C+N-1:0]      acc_reg, acc_next;
    logic [C-1:0]        denom_reg;
    logic signed [C:0]   xlo_off_reg, xlo_off_next, xhi_off_reg, xhi_off_next;
    logic signed [C-1:0] sy_reg, ey_reg;
    srot_flags_t         flags_reg, flags_next;
    logic signed [C-1:0] xlo;
    logic signed [C:0]   xhi, off_lo, off_hi;

    always_comb
    begin
        dx        = (C+1)'(end_x) - (C+1)'(start_x);
        dy        = (C+1)'(end_y) - (C+1)'(start_y);
        adx_next  = dx[C] ? C'(-dx) : C'(dx);
        ady_next  = dy[C] ? C'(-dy) : C'(dy);
        neg_next  = dx[C] ^ dy[C];
        vert_next = (dx == '0);
        lo_next   = (start_x < end_x) ? start_x : end_x;
        hi_next   = (start_x < end_x) ? end_x : start_x;
    end

    always_comb
    begin
        xlo    = (lo_reg > rect_left) ? lo_reg : rect_left;
        xhi    = ((C+1)'(hi_reg) < rect_right) ? (C+1)'(hi_reg) : rect_right;
        off_lo = (C+1)'(xlo) - (C+1)'(s0_sx_reg);
        off_hi = xhi - (C+1)'(s0_sx_reg);
        xlo_off_next    = neg_reg ? -off_lo : off_lo;
        xhi_off_next    = neg_reg ? -off_hi : off_hi;
        acc_next        = {{C{1'b0}}, ady_reg, {F{1'b0}}};
        flags_next.vert = vert_reg;
        flags_next.miss = ((C+1)'(xlo) > xhi);
    end

    // Handshake: each stage takes a new transaction when it is empty or draining
    assign s1_ready      = !s1_valid_reg || out_ready;
    assign s0_ready      = !s0_valid_reg || s1_ready;
    assign s0_load       = in_valid && s0_ready;
    assign s1_load       = s0_valid_reg && s1_ready;
    assign s0_valid_next = s0_ready ? in_valid : s0_valid_reg;
    assign s1_valid_next = s1_ready ? s0_valid_reg : s1_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= s0_valid_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Hold stage 0 payload
    always_ff @(posedge clk)
    begin
        if (s0_load)
        begin
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            s0_sx_reg <= start_x;
            s0_sy_reg <= start_y;
            s0_ey_reg <= end_y;
            adx_reg   <= adx_next;
            ady_reg   <= ady_next;
            neg_reg   <= neg_next;
            vert_reg  <= vert_next;
        end
    end

    // Hold stage 1 payload
    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            acc_reg     <= acc_next;
            denom_reg   <= adx_reg;
            xlo_off_reg <= xlo_off_next;
            xhi_off_reg <= xhi_off_next;
            sy_reg      <= s0_sy_reg;
            ey_reg      <= s0_ey_reg;
            flags_reg   <= flags_next;
        end
    end

    assign in_ready  = s0_ready;
    assign out_valid = s1_valid_reg;
    assign acc       = acc_reg;
    assign denom     = denom_reg;
    assign xlo_off   = xlo_off_reg;
    assign xhi_off   = xhi_off_reg;
    assign sy        = sy_reg;
    assign ey        = ey_reg;
    assign flags     = flags_reg;

endmodule

FILE: src/srot_div_cell.sv
module srot_div_cell #(
    parameter int COORD_BITS      = srot_pkg::COORD_BITS_DEF,
    parameter int SLOPE_FRAC_BITS = srot_pkg::SLOPE_FRAC_BITS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic [2*COORD_BITS+SLOPE_FRAC_BITS-1:0] acc_in,
    input  logic [COORD_BITS-1:0]                   denom_in,
    input  logic signed [COORD_BITS:0]              xlo_off_in,
    input  logic signed [COORD_BITS:0]              xhi_off_in,
    input  logic signed [COORD_BITS-1:0]            sy_in,
    input  logic signed [COORD_BITS-1:0]            ey_in,
    input  srot_pkg::srot_flags_t                   flags_in,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic [2*COORD_BITS+SLOPE_FRAC_BITS-1:0] acc_out,
    output logic [COORD_BITS-1:0]                   denom_out,
    output logic signed [COORD_BITS:0]              xlo_off_out,
    output logic signed [COORD_BITS:0]              xhi_off_out,
    output logic signed [COORD_BITS-1:0]            sy_out,
    output logic signed [COORD_BITS-1:0]            ey_out,
    output srot_pkg::srot_flags_t                   flags_out
);
    import srot_pkg::*;

    localparam int C = COORD_BITS;
    localparam int N = COORD_BITS + SLOPE_FRAC_BITS;

    // acc holds {remainder, dividend bits still to shift in / quotient bits so far}
    logic              valid_reg, valid_next, ready, load;
    logic [C+N-1:0]    acc_reg, acc_next;
    logic [C-1:0]      denom_reg;
    logic signed [C:0] xlo_off_reg, xhi_off_reg;
    logic signed [C-1:0] sy_reg, ey_reg;
    srot_flags_t       flags_reg;
    logic [C:0]        trial;
    logic [C+1:0]      diff;
    logic              take;
    logic [C-1:0]      rem_next;

    // One restoring division step: shift in a dividend bit, subtract if it fits
    always_comb
    begin
        trial    = {acc_in[C+N-1:N], acc_in[N-1]};
        diff     = {1'b0, trial} - {2'b00, denom_in};
        take     = !diff[C+1];
        rem_next = take ? diff[C-1:0] : trial[C-1:0];
        acc_next = {rem_next, acc_in[N-2:0], take};
    end

    assign ready      = !valid_reg || out_ready;
    assign load       = in_valid && ready;
    assign valid_next = ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Advance the transaction to this cell
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            acc_reg     <= acc_next;
            denom_reg   <= denom_in;
            xlo_off_reg <= xlo_off_in;
            xhi_off_reg <= xhi_off_in;
            sy_reg      <= sy_in;
            ey_reg      <= ey_in;
            flags_reg   <= flags_in;
        end
    end

    assign in_ready    = ready;
    assign out_valid   = valid_reg;
    assign acc_out     = acc_reg;
    assign denom_out   = denom_reg;
    assign xlo_off_out = xlo_off_reg;
    assign xhi_off_out = xhi_off_reg;
    assign sy_out      = sy_reg;
    assign ey_out      = ey_reg;
    assign flags_out   = flags_reg;

endmodule

FILE: src/srot_back.sv
module srot_back #(
    parameter int COORD_BITS      = srot_pkg::COORD_BITS_DEF,
    parameter int SLOPE_FRAC_BITS = srot_pkg::SLOPE_FRAC_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [COORD_BITS+SLOPE_FRAC_BITS-1:0] quot,
    input  logic signed [COORD_BITS:0]            xlo_off,
    input  logic signed [COORD_BITS:0]            xhi_off,
    input  logic signed [COORD_BITS-1:0]          sy,
    input  logic signed [COORD_BITS-1:0]          ey,
    input  srot_pkg::srot_flags_t                 flags,
    input  logic signed [COORD_BITS-1:0]          rect_top,
    input  logic signed [COORD_BITS:0]            rect_bot,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  hit
);
    import srot_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int F  = SLOPE_FRAC_BITS;
    localparam int N  = C + F;
    localparam int PW = N + C + 2;
    localparam int YW = PW + 1;

    // Stage A: slope magnitude times sign-folded x offsets
    logic                 a_valid_reg, a_valid_next, a_ready, a_load;
    logic signed [N:0]    qs;
    logic signed [PW-1:0] pa_reg, pa_next, pb_reg, pb_next;
    logic signed [C-1:0]  a_sy_reg, a_ey_reg;
    srot_flags_t          a_flags_reg;

    // Stage B: add the intercept, or take endpoint y for a vertical segment
    logic                 b_valid_reg, b_valid_next, b_ready, b_load;
    logic signed [YW-1:0] sy_f, ey_f;
    logic signed [YW-1:0] ya_reg, ya_next, yb_reg, yb_next;
    logic                 b_miss_reg;

    // Stage C: sort the y pair and test it against the y span
    logic                 c_valid_reg, c_valid_next, c_ready, c_load;
    logic signed [YW-1:0] y_lo, y_hi, top_f, bot_f;
    logic                 hit_reg, hit_next;

    always_comb
    begin
        qs      = $signed({1'b0, quot});
        pa_next = PW'(qs) * PW'(xlo_off);
        pb_next = PW'(qs) * PW'(xhi_off);
    end

    always_comb
    begin
        sy_f    = YW'(a_sy_reg) <<< F;
        ey_f    = YW'(a_ey_reg) <<< F;
        ya_next = a_flags_reg.vert ? sy_f : (YW'(pa_reg) + sy_f);
        yb_next = a_flags_reg.vert ? ey_f : (YW'(pb_reg) + sy_f);
    end

    always_comb
    begin
        top_f    = YW'(rect_top) <<< F;
        bot_f    = YW'(rect_bot) <<< F;
        y_lo     = (ya_reg < yb_reg) ? ya_reg : yb_reg;
        y_hi     = (ya_reg < yb_reg) ? yb_reg : ya_reg;
        hit_next = !b_miss_reg && (y_lo <= bot_f) && (y_hi >= top_f);
    end

    // Handshake chain through the three stages
    assign c_ready      = !c_valid_reg || out_ready;
    assign b_ready      = !b_valid_reg || c_ready;
    assign a_ready      = !a_valid_reg || b_ready;
    assign a_load       = in_valid && a_ready;
    assign b_load       = a_valid_reg && b_ready;
    assign c_load       = b_valid_reg && c_ready;
    assign a_valid_next = a_ready ? in_valid : a_valid_reg;
    assign b_valid_next = b_ready ? a_valid_reg : b_valid_reg;
    assign c_valid_next = c_ready ? b_valid_reg : c_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            c_valid_reg <= c_valid_next;
        end
    end

    // Hold stage payloads
    always_ff @(posedge clk)
    begin
        if (a_load)
        begin
            pa_reg      <= pa_next;
            pb_reg      <= pb_next;
            a_sy_reg    <= sy;
            a_ey_reg    <= ey;
            a_flags_reg <= flags;
        end
        if (b_load)
        begin
            ya_reg     <= ya_next;
            yb_reg     <= yb_next;
            b_miss_reg <= a_flags_reg.miss;
        end
        if (c_load)
        begin
            hit_reg <= hit_next;
        end
    end

    assign in_ready  = a_ready;
    assign out_valid = c_valid_reg;
    assign hit       = hit_reg;

endmodule

FILE: src/segment_rect_overlap_test.sv
// Channel   Direction  Handshake                 Payload
// config    in         psel/penable/pwrite/pready paddr, pwdata, prdata
// segment   in         in_valid / in_ready       start_x, start_y, end_x, end_y
// result    out        out_valid / out_ready     hit
//
// One transaction per cycle sustained while results are taken; a segment's result
// passes through the front stages, the divider cells and the back stages in order.
// The divider chain yields one quotient bit per cell.
// Reset clears all stage valid bits and loads the rectangle reset values.
// A stalled result holds its stage; earlier stages keep filling empty slots.
module segment_rect_overlap_test #(
    parameter int COORD_BITS      = srot_pkg::COORD_BITS_DEF,
    parameter int SLOPE_FRAC_BITS = srot_pkg::SLOPE_FRAC_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [srot_pkg::CFG_ADDR_BITS-1:0]   paddr,
    input  logic [srot_pkg::CFG_DATA_BITS-1:0]   pwdata,
    output logic [srot_pkg::CFG_DATA_BITS-1:0]   prdata,
    output logic                                 pready,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [COORD_BITS-1:0]         start_x,
    input  logic signed [COORD_BITS-1:0]         start_y,
    input  logic signed [COORD_BITS-1:0]         end_x,
    input  logic signed [COORD_BITS-1:0]         end_y,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 hit
);
    import srot_pkg::*;

    localparam int C = COORD_BITS;
    localparam int N = C + SLOPE_FRAC_BITS;

    // Rectangle registers and their derived far edges
    logic signed [C-1:0] rect_left_reg, rect_top_reg;
    logic [C-2:0]        rect_width_reg, rect_height_reg;
    logic signed [C:0]   rect_right_reg, rect_right_next;
    logic signed [C:0]   rect_bot_reg, rect_bot_next;
    logic                cfg_write;
    srot_reg_t           cfg_sel;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_sel   = srot_reg_t'(paddr[CFG_ADDR_BITS-1:2]);

    assign rect_right_next = (C+1)'(rect_left_reg) + (C+1)'(rect_width_reg);
    assign rect_bot_next   = (C+1)'(rect_top_reg) + (C+1)'(rect_height_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rect_left_reg   <= '0;
            rect_top_reg    <= '0;
            rect_width_reg  <= (C-1)'(RECT_SIZE_RESET);
            rect_height_reg <= (C-1)'(RECT_SIZE_RESET);
            rect_right_reg  <= (C+1)'(RECT_SIZE_RESET);
            rect_bot_reg    <= (C+1)'(RECT_SIZE_RESET);
        end
        else
        begin
            rect_right_reg <= rect_right_next;
            rect_bot_reg   <= rect_bot_next;
            if (cfg_write)
            begin
                case (cfg_sel)
                    REG_RECT_LEFT:   rect_left_reg   <= pwdata[C-1:0];
                    REG_RECT_TOP:    rect_top_reg    <= pwdata[C-1:0];
                    REG_RECT_WIDTH:  rect_width_reg  <= pwdata[C-2:0];
                    REG_RECT_HEIGHT: rect_height_reg <= pwdata[C-2:0];
                    default:         ;
                endcase
            end
        end
    end

    // Read back: signed edges sign-extended, sizes zero-extended
    always_comb
    begin
        case (cfg_sel)
            REG_RECT_LEFT:   prdata = CFG_DATA_BITS'(rect_left_reg);
            REG_RECT_TOP:    prdata = CFG_DATA_BITS'(rect_top_reg);
            REG_RECT_WIDTH:  prdata = CFG_DATA_BITS'(rect_width_reg);
            REG_RECT_HEIGHT: prdata = CFG_DATA_BITS'(rect_height_reg);
            default:         prdata = '0;
        endcase
    end

    // Links between the front stage, the divider cells and the back stages
    logic                dv_valid   [0:N];
    logic                dv_ready   [0:N];
    logic [C+N-1:0]      dv_acc     [0:N];
    logic [C-1:0]        dv_denom   [0:N];
    logic signed [C:0]   dv_xlo_off [0:N];
    logic signed [C:0]   dv_xhi_off [0:N];
    logic signed [C-1:0] dv_sy      [0:N];
    logic signed [C-1:0] dv_ey      [0:N];
    srot_flags_t         dv_flags   [0:N];

    srot_front #(
        .COORD_BITS      (COORD_BITS),
        .SLOPE_FRAC_BITS (SLOPE_FRAC_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .start_x    (start_x),
        .start_y    (start_y),
        .end_x      (end_x),
        .end_y      (end_y),
        .rect_left  (rect_left_reg),
        .rect_right (rect_right_reg),
        .out_valid  (dv_valid[0]),
        .out_ready  (dv_ready[0]),
        .acc        (dv_acc[0]),
        .denom      (dv_denom[0]),
        .xlo_off    (dv_xlo_off[0]),
        .xhi_off    (dv_xhi_off[0]),
        .sy         (dv_sy[0]),
        .ey         (dv_ey[0]),
        .flags      (dv_flags[0])
    );

    // Divider chain: one quotient bit per cell, most significant first
    for (genvar k = 0; k < N; k++)
    begin : g_cell
        srot_div_cell #(
            .COORD_BITS      (COORD_BITS),
            .SLOPE_FRAC_BITS (SLOPE_FRAC_BITS)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .in_valid    (dv_valid[k]),
            .in_ready    (dv_ready[k]),
            .acc_in      (dv_acc[k]),
            .denom_in    (dv_denom[k]),
            .xlo_off_in  (dv_xlo_off[k]),
            .xhi_off_in  (dv_xhi_off[k]),
            .sy_in       (dv_sy[k]),
            .ey_in       (dv_ey[k]),
            .flags_in    (dv_flags[k]),
            .out_valid   (dv_valid[k+1]),
            .out_ready   (dv_ready[k+1]),
            .acc_out     (dv_acc[k+1]),
            .denom_out   (dv_denom[k+1]),
            .xlo_off_out (dv_xlo_off[k+1]),
            .xhi_off_out (dv_xhi_off[k+1]),
            .sy_out      (dv_sy[k+1]),
            .ey_out      (dv_ey[k+1]),
            .flags_out   (dv_flags[k+1])
        );
    end

    srot_back #(
        .COORD_BITS      (COORD_BITS),
        .SLOPE_FRAC_BITS (SLOPE_FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dv_valid[N]),
        .in_ready  (dv_ready[N]),
        .quot      (dv_acc[N][N-1:0]),
        .xlo_off   (dv_xlo_off[N]),
        .xhi_off   (dv_xhi_off[N]),
        .sy        (dv_sy[N]),
        .ey        (dv_ey[N]),
        .flags     (dv_flags[N]),
        .rect_top  (rect_top_reg),
        .rect_bot  (rect_bot_reg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .hit       (hit)
    );

endmodule

FILE: src/srot_check.sv
module srot_check #(
    parameter int COORD_BITS      = srot_pkg::COORD_BITS_DEF,
    parameter int SLOPE_FRAC_BITS = srot_pkg::SLOPE_FRAC_BITS_DEF
) (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 psel,
    input logic                                 penable,
    input logic                                 pwrite,
    input logic [srot_pkg::CFG_ADDR_BITS-1:0]   paddr,
    input logic [srot_pkg::CFG_DATA_BITS-1:0]   pwdata,
    input logic [srot_pkg::CFG_DATA_BITS-1:0]   prdata,
    input logic                                 pready,
    input logic                                 in_valid,
    input logic                                 in_ready,
    input logic                                 out_valid,
    input logic                                 out_ready,
    input logic                                 hit
);
    import srot_pkg::*;

    localparam int C      = COORD_BITS;
    localparam int STAGES = COORD_BITS + SLOPE_FRAC_BITS + 5;
    localparam int CW     = $clog2(STAGES + 2) + 1;

    // Count transactions in flight
    logic          in_acc, out_acc, wr_left, rd_left, rd_width;
    logic [CW-1:0] count_reg, count_next;

    assign in_acc   = in_valid && in_ready;
    assign out_acc  = out_valid && out_ready;
    assign wr_left  = psel && penable && pwrite && pready
                      && (paddr[CFG_ADDR_BITS-1:2] == REG_RECT_LEFT);
    assign rd_left  = psel && !pwrite && (paddr[CFG_ADDR_BITS-1:2] == REG_RECT_LEFT);
    assign rd_width = psel && !pwrite && (paddr[CFG_ADDR_BITS-1:2] == REG_RECT_WIDTH);

    assign count_next = count_reg + CW'(in_acc) - CW'(out_acc);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // A stalled result keeps its value
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(hit))
        else $error("result changed while stalled");

    // No result without a segment in flight
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> count_reg != '0)
        else $error("result with no segment in flight");

    // The pipeline never holds more than one transaction per stage
    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(STAGES))
        else $error("more transactions in flight than stages");

    // Width reads back zero-extended
    a_width_read: assert property (@(posedge clk) disable iff (!rst_n)
        rd_width |-> prdata[CFG_DATA_BITS-1:C-1] == '0)
        else $error("width read back with high bits set");

    // A left edge write reads back on the next cycle
    a_left_read: assert property (@(posedge clk) disable iff (!rst_n)
        wr_left ##1 rd_left |-> prdata[C-1:0] == $past(pwdata[C-1:0]))
        else $error("left edge read back differs from write");

endmodule

bind segment_rect_overlap_test srot_check #(
    .COORD_BITS      (COORD_BITS),
    .SLOPE_FRAC_BITS (SLOPE_FRAC_BITS)
) u_srot_check (.*);
